>>> src/ffca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared constants, codes, command and status types for the first-fit
// contiguous allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int DEF_MAP_UNITS = 4096;
    localparam int DEF_MAX_FILES = 256;

    // fixed field widths
    localparam int ACTION_W = 2;
    localparam int ID_W     = 8;
    localparam int SIZE_W   = 13;
    localparam int STATUS_W = 2;
    localparam int START_W  = 12;
    localparam int LEN_W    = 13;
    localparam int IFRAG_W  = 12;
    localparam int EFRAG_W  = 32;

    // map word: eight units per word, scanned one word per cycle
    localparam int MAP_WORD_W = 8;

    localparam logic [ACTION_W-1:0] ACT_CREATE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IDSFULL = 2'd3;

    typedef struct packed {
        logic                clr_step;
        logic                load;
        logic                scan_init;
        logic                scan_step;
        logic                ent_latch;
        logic                mark_init;
        logic                mark_step;
        logic                set_status;
        logic [STATUS_W-1:0] status_code;
        logic                commit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_create;
        logic is_delete;
        logic ids_full;
        logic size_bad;
        logic unknown;
        logic found;
        logic scan_last;
        logic mark_last;
        logic out_free;
    } t_sts;

    // x mod 10 by reciprocal multiply, exact for x below 2^17
    function automatic logic [3:0] mod10(input logic [16:0] x);
        logic [33:0] p;
        logic [14:0] q;
        logic [16:0] r;
        p = 34'(x) * 34'd52429;
        q = p[33:19];
        r = x - 17'(q * 15'd10);
        return r[3:0];
    endfunction

endpackage

>>> src/ffca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/ffca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer: map clearing pass, dispatch, first-fit scan, entry read,
// run marking and result commit.
// ----------------------------------------------------------------------------
module ffca_ctrl
    import ffca_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISP     = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_ENT_WAIT = 4'd4;
    localparam logic [3:0] S_MARK0    = 4'd5;
    localparam logic [3:0] S_MARK     = 4'd6;
    localparam logic [3:0] S_FIN      = 4'd7;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.is_create) begin
                    if (i_sts.ids_full) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_IDSFULL;
                        n_state           = S_FIN;
                    end else if (i_sts.size_bad) begin
                        o_cmd.set_status  = 1'b1;
                        o_cmd.status_code = ST_NOSPACE;
                        n_state           = S_FIN;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                end else if (i_sts.unknown) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_UNKNOWN;
                    n_state           = S_FIN;
                end else begin
                    n_state = S_ENT_WAIT;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.found) begin
                    n_state = S_MARK0;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_status  = 1'b1;
                    o_cmd.status_code = ST_NOSPACE;
                    n_state           = S_FIN;
                end
            end
            S_ENT_WAIT: begin
                o_cmd.ent_latch = 1'b1;
                n_state         = i_sts.is_delete ? S_MARK0 : S_FIN;
            end
            S_MARK0: begin
                o_cmd.mark_init = 1'b1;
                n_state         = S_MARK;
            end
            S_MARK: begin
                o_cmd.mark_step = 1'b1;
                if (i_sts.mark_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

>>> src/ffca_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffca_dpath
// Datapath: unit map RAM, file entry RAM, valid bits, id counter,
// fragmentation totals, scan and mark logic, result register.
// ----------------------------------------------------------------------------
module ffca_dpath
    import ffca_pkg::*;
#(
    parameter int MAP_UNITS = DEF_MAP_UNITS,
    parameter int MAX_FILES = DEF_MAX_FILES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [ID_W-1:0]     i_file_id,
    input  logic [SIZE_W-1:0]   i_request_size,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_assigned_id,
    output logic [START_W-1:0]  o_run_start,
    output logic [LEN_W-1:0]    o_run_length,
    output logic [IFRAG_W-1:0]  o_internal_frag,
    output logic [EFRAG_W-1:0]  o_external_frag
);

    localparam int UW  = $clog2(MAP_UNITS);
    localparam int CW  = $clog2(MAP_UNITS + 1);
    localparam int NW  = (MAP_UNITS + MAP_WORD_W - 1) / MAP_WORD_W;
    localparam int WA  = $clog2(NW);
    localparam int XW  = WA + 4;
    localparam int IW  = $clog2(MAX_FILES);
    localparam int NXW = $clog2(MAX_FILES + 1);
    localparam int EW  = UW + CW;

    logic [ACTION_W-1:0] r_action;
    logic [ID_W-1:0]     r_fid;
    logic [SIZE_W-1:0]   r_size;
    logic [STATUS_W-1:0] r_status;
    logic [UW-1:0]       r_start;
    logic [CW-1:0]       r_len;
    logic [CW-1:0]       r_run;
    logic [WA-1:0]       r_caddr;
    logic [WA-1:0]       r_paddr;
    logic [WA-1:0]       r_maddr;
    logic [MAX_FILES-1:0] r_valid;
    logic [NXW-1:0]      r_next;
    logic [IFRAG_W-1:0]  r_ifrag;
    logic [EFRAG_W-1:0]  r_efrag;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [ID_W-1:0]     r_o_id;
    logic [START_W-1:0]  r_o_start;
    logic [LEN_W-1:0]    r_o_len;

    // map ram
    logic                  map_we;
    logic [WA-1:0]         map_waddr;
    logic [MAP_WORD_W-1:0] map_wdata;
    logic [WA-1:0]         map_raddr;
    logic [MAP_WORD_W-1:0] map_rdata;

    // entry ram
    logic          ent_we;
    logic [EW-1:0] ent_rdata;

    ffca_ram #(.WIDTH(MAP_WORD_W), .DEPTH(NW)) u_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    ffca_ram #(.WIDTH(EW), .DEPTH(MAX_FILES)) u_ent (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (IW'(r_next)),
        .i_wdata ({r_start, r_len}),
        .i_raddr (IW'(r_fid)),
        .o_rdata (ent_rdata)
    );

    logic            is_create;
    logic            is_delete;
    logic            is_ok;
    logic [3:0]      len_mod;
    logic [XW-1:0]   run_end;
    logic [WA-1:0]   mark_first;
    logic [WA-1:0]   mark_lastw;
    logic [CW-1:0]   scan_run;
    logic            scan_found;
    logic [XW-1:0]   scan_pos;
    logic [XW-1:0]   unit;
    logic [MAP_WORD_W-1:0] mark_word;
    logic [EFRAG_W:0]      efrag_sum;
    logic [IFRAG_W-1:0]    n_ifrag;
    logic [EFRAG_W-1:0]    n_efrag;

    assign is_create  = (r_action == ACT_CREATE);
    assign is_delete  = (r_action == ACT_DELETE);
    assign is_ok      = (r_status == ST_OK);
    assign len_mod    = mod10(17'(r_len));
    assign run_end    = XW'(r_start) + XW'(r_len);
    assign mark_first = WA'(r_start >> 3);
    assign mark_lastw = WA'((run_end - XW'(1)) >> 3);

    // one map word of the first-fit scan, run length carried across words
    always_comb begin
        logic [CW-1:0] run;
        logic          fnd;
        logic [XW-1:0] u;
        run      = r_run;
        fnd      = 1'b0;
        scan_pos = '0;
        for (int i = 0; i < MAP_WORD_W; i++) begin
            u = XW'({r_paddr, 3'(i)});
            if (!fnd) begin
                if (map_rdata[i] || (32'(u) >= MAP_UNITS)) begin
                    run = '0;
                end else begin
                    run = run + CW'(1);
                    if (run >= r_len) begin
                        fnd      = 1'b1;
                        scan_pos = u;
                    end
                end
            end
        end
        scan_run   = run;
        scan_found = fnd;
    end

    // set or clear the run's bits within the current word
    always_comb begin
        mark_word = map_rdata;
        unit      = '0;
        for (int i = 0; i < MAP_WORD_W; i++) begin
            unit = XW'({r_maddr, 3'(i)});
            if ((unit >= XW'(r_start)) && (unit < run_end)) begin
                mark_word[i] = is_create;
            end
        end
    end

    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_caddr;
        map_wdata = '0;
        map_raddr = '0;
        if (i_cmd.clr_step) begin
            map_we = 1'b1;
        end else if (i_cmd.mark_step) begin
            map_we    = 1'b1;
            map_waddr = r_maddr;
            map_wdata = mark_word;
        end
        if (i_cmd.scan_step) begin
            map_raddr = r_paddr + WA'(1);
        end else if (i_cmd.mark_init) begin
            map_raddr = mark_first;
        end else if (i_cmd.mark_step) begin
            map_raddr = r_maddr + WA'(1);
        end
    end

    assign ent_we = i_cmd.commit && is_create && is_ok;

    assign efrag_sum = (EFRAG_W + 1)'(r_efrag) + (EFRAG_W + 1)'(r_size);

    always_comb begin
        n_ifrag = r_ifrag;
        n_efrag = r_efrag;
        if (is_create && is_ok) begin
            n_ifrag = r_ifrag + IFRAG_W'(len_mod);
        end else if (is_delete && is_ok) begin
            n_ifrag = r_ifrag - IFRAG_W'(len_mod);
        end
        if (is_create && (r_status == ST_NOSPACE)) begin
            n_efrag = efrag_sum[EFRAG_W] ? '1 : efrag_sum[EFRAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr     <= '0;
            r_valid     <= '0;
            r_next      <= NXW'(1);
            r_ifrag     <= '0;
            r_efrag     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_caddr <= r_caddr + WA'(1);
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_ifrag     <= n_ifrag;
                r_efrag     <= n_efrag;
                if (is_create && is_ok) begin
                    r_valid[IW'(r_next)] <= 1'b1;
                    r_next               <= r_next + NXW'(1);
                end else if (is_delete && is_ok) begin
                    r_valid[IW'(r_fid)] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_fid    <= i_file_id;
            r_size   <= i_request_size;
            r_len    <= CW'(i_request_size);
            r_status <= ST_OK;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status_code;
        end
        if (i_cmd.scan_init) begin
            r_paddr <= '0;
            r_run   <= '0;
        end
        if (i_cmd.scan_step) begin
            r_paddr <= r_paddr + WA'(1);
            r_run   <= scan_run;
            if (scan_found) begin
                r_start <= UW'(scan_pos + XW'(1) - XW'(r_len));
            end
        end
        if (i_cmd.ent_latch) begin
            r_start <= ent_rdata[EW-1:CW];
            r_len   <= ent_rdata[CW-1:0];
        end
        if (i_cmd.mark_init) begin
            r_maddr <= mark_first;
        end
        if (i_cmd.mark_step) begin
            r_maddr <= r_maddr + WA'(1);
        end
        if (i_cmd.commit) begin
            r_o_status <= r_status;
            r_o_id     <= is_create ? (is_ok ? ID_W'(r_next) : '0) : r_fid;
            r_o_start  <= is_ok ? START_W'(r_start) : '0;
            r_o_len    <= is_ok ? LEN_W'(r_len) : '0;
        end
    end

    assign o_sts.clr_last  = (r_caddr == WA'(NW - 1));
    assign o_sts.is_create = is_create;
    assign o_sts.is_delete = is_delete;
    assign o_sts.ids_full  = (32'(r_next) >= MAX_FILES);
    assign o_sts.size_bad  = (r_size == '0) || (32'(r_size) > MAP_UNITS);
    assign o_sts.unknown   = (32'(r_fid) >= MAX_FILES) || !r_valid[IW'(r_fid)];
    assign o_sts.found     = scan_found;
    assign o_sts.scan_last = (r_paddr == WA'(NW - 1));
    assign o_sts.mark_last = (r_maddr == mark_lastw);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_assigned_id   = r_o_id;
    assign o_run_start     = r_o_start;
    assign o_run_length    = r_o_len;
    assign o_internal_frag = r_ifrag;
    assign o_external_frag = r_efrag;

    a_next_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && is_create && is_ok) |=> (r_next == $past(r_next) + NXW'(1)))
        else $error("id counter did not advance on a successful create");

    a_next_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next != '0)
        else $error("id counter reached zero");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_status == ST_OK) && (r_o_id != '0)) |-> (r_o_len != '0))
        else $error("successful result with empty run");

    a_run_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mark_step |-> (32'(run_end) <= MAP_UNITS))
        else $error("marked run extends past the map");

endmodule

>>> src/first_fit_contiguous_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_contiguous_allocator
// First-fit contiguous allocator over a unit map with a file table,
// fragmentation totals and one result beat per request.
//
// channel   dir  tdata                         tuser
// s_axis    in   file_id, request_size         action
// m_axis    out  assigned_id, run_start,       status
//                run_length, internal_frag,
//                external_frag
//
// after reset a clearing pass writes the map, one word a cycle, with
// s_axis_tready low. create: dispatch, then a first-fit scan of one 8-unit
// map word per cycle, then marking of every word the run spans; delete:
// dispatch, entry read, then marking of the words spanned; lookup and
// rejected requests: dispatch, plus an entry read for lookup, then commit.
// one request at a time; a finished result waits in the output register
// and stalls the commit of the next one only while it is still untaken.
// ----------------------------------------------------------------------------
module first_fit_contiguous_allocator
    import ffca_pkg::*;
#(
    parameter int MAP_UNITS = DEF_MAP_UNITS,
    parameter int MAX_FILES = DEF_MAX_FILES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // file_id[7:0], request_size[20:8], zero
    input  logic [1:0]  s_axis_tuser,  // action[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,  // assigned_id[7:0], run_start[19:8],
                                       // run_length[32:20], internal_frag[44:33],
                                       // external_frag[76:45], zero
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    t_cmd cmd;
    t_sts sts;

    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     assigned_id;
    logic [START_W-1:0]  run_start;
    logic [LEN_W-1:0]    run_length;
    logic [IFRAG_W-1:0]  internal_frag;
    logic [EFRAG_W-1:0]  external_frag;

    ffca_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ffca_dpath #(
        .MAP_UNITS (MAP_UNITS),
        .MAX_FILES (MAX_FILES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (s_axis_tuser),
        .i_file_id       (s_axis_tdata[7:0]),
        .i_request_size  (s_axis_tdata[20:8]),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_status        (status),
        .o_assigned_id   (assigned_id),
        .o_run_start     (run_start),
        .o_run_length    (run_length),
        .o_internal_frag (internal_frag),
        .o_external_frag (external_frag)
    );

    assign m_axis_tuser = status;
    assign m_axis_tdata = {3'b000, external_frag, internal_frag, run_length,
                           run_start, assigned_id};

endmodule

>>> tb/sv/tb_first_fit_contiguous_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_contiguous_allocator
// Self-checking bench for the first-fit allocator. Requests are mirrored into
// a behavioral model of the unit map and file table. Every result beat is
// compared field by field against the oldest predicted answer. The stimulus
// runs in this order: edge cases, random allocate/free traffic, a long output
// stall, and id exhaustion.
// ----------------------------------------------------------------------------
module tb_first_fit_contiguous_allocator;
    import ffca_pkg::*;

    localparam int                  UNITS        = DEF_MAP_UNITS;
    localparam int                  FILES        = DEF_MAX_FILES;
    localparam logic [ACTION_W-1:0] ACT_RESERVED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [START_W-1:0]  start;
        logic [LEN_W-1:0]    len;
        logic [IFRAG_W-1:0]  ifrag;
        logic [EFRAG_W-1:0]  efrag;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // file_id[7:0], request_size[20:8], zero
    logic [1:0]  s_axis_tuser;   // action[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // assigned_id, run_start, run_length, ifrag, efrag
    logic [1:0]  m_axis_tuser;   // status[1:0]

    // model state
    bit                 unit_busy [UNITS];
    logic [START_W-1:0] file_start [FILES];
    logic [LEN_W-1:0]   file_len [FILES];
    bit                 file_live [FILES];
    int unsigned        next_id;
    logic [IFRAG_W-1:0] ifrag_total;
    logic [EFRAG_W-1:0] efrag_total;
    int                 live_ids[$];

    t_answer     pending_answers[$];
    int unsigned err_cnt;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned n_ok;
    int unsigned n_nospace;
    int unsigned n_unknown;
    int unsigned n_idsfull;
    int unsigned hold_cycles;
    int unsigned ready_pct;
    int unsigned burst_left;

    first_fit_contiguous_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("[first_fit_contiguous_allocator] ERROR");
        $finish;
    end

    // lowest free run of len units, -1 if none
    function automatic int first_free_run(int unsigned len);
        int unsigned run;
        run = 0;
        if (len == 0 || len > UNITS) return -1;
        for (int u = 0; u < UNITS; u++) begin
            if (unit_busy[u]) begin
                run = 0;
            end else begin
                run++;
                if (run >= len) return u + 1 - len;
            end
        end
        return -1;
    endfunction

    task automatic apply_request(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] fid,
                                 input logic [SIZE_W-1:0] size);
        t_answer a;
        int      s;
        a = '0;
        if (act == ACT_CREATE) begin
            if (next_id >= FILES) begin
                a.status = ST_IDSFULL;
            end else begin
                s = first_free_run(size);
                if (s < 0) begin
                    a.status = ST_NOSPACE;
                    if (efrag_total > 32'hFFFF_FFFF - size) efrag_total = 32'hFFFF_FFFF;
                    else efrag_total = efrag_total + size;
                end else begin
                    a.status = ST_OK;
                    a.id     = ID_W'(next_id);
                    a.start  = START_W'(s);
                    a.len    = size;
                    for (int u = s; u < s + size; u++) unit_busy[u] = 1'b1;
                    file_start[next_id] = a.start;
                    file_len[next_id]   = size;
                    file_live[next_id]  = 1'b1;
                    live_ids.push_back(next_id);
                    ifrag_total = ifrag_total + IFRAG_W'(size % 10);
                    next_id++;
                end
            end
        end else begin
            a.id = fid;
            if (!file_live[fid]) begin
                a.status = ST_UNKNOWN;
            end else begin
                a.status = ST_OK;
                a.start  = file_start[fid];
                a.len    = file_len[fid];
                if (act == ACT_DELETE) begin
                    for (int u = a.start; u < a.start + a.len && u < UNITS; u++)
                        unit_busy[u] = 1'b0;
                    file_live[fid] = 1'b0;
                    foreach (live_ids[k]) if (live_ids[k] == fid) begin
                        live_ids.delete(k);
                        break;
                    end
                    ifrag_total = ifrag_total - IFRAG_W'(a.len % 10);
                end
            end
        end
        a.ifrag = ifrag_total;
        a.efrag = efrag_total;
        case (a.status)
            ST_OK:      n_ok++;
            ST_NOSPACE: n_nospace++;
            ST_UNKNOWN: n_unknown++;
            default:    n_idsfull++;
        endcase
        pending_answers.push_back(a);
    endtask

    // one request beat; called at a falling edge, returns at a falling edge
    task automatic send_req(input logic [ACTION_W-1:0] act, input logic [ID_W-1:0] fid,
                            input logic [SIZE_W-1:0] size);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            burst_left = $urandom_range(1, 16);
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        burst_left--;
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {3'b000, size, fid};
        do @(posedge i_clk); while (!s_axis_tready);
        apply_request(act, fid, size);
        beats_in++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
    endtask

    // mostly small sizes, a few large and oversized ones
    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return SIZE_W'($urandom_range(1, 40));
        if (r < 90) return SIZE_W'($urandom_range(41, 400));
        if (r < 97) return SIZE_W'($urandom_range(401, 4096));
        return SIZE_W'($urandom_range(0, 8191));
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if (live_ids.size() != 0 && $urandom_range(0, 9) < 8)
            return ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
        return ID_W'($urandom_range(0, 255));
    endfunction

    task automatic send_random();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)      send_req(ACT_CREATE, ID_W'($urandom), pick_size());
        else if (r < 75) send_req(ACT_DELETE, pick_id(), SIZE_W'($urandom));
        else if (r < 95) send_req(ACT_LOOKUP, pick_id(), SIZE_W'($urandom));
        else             send_req(ACT_RESERVED, pick_id(), SIZE_W'($urandom));
    endtask

    task automatic test_corner_cases();
        send_req(ACT_CREATE, 8'hFF, 13'd0);        // zero size
        send_req(ACT_CREATE, 8'h00, 13'h1FFF);     // oversized
        send_req(ACT_CREATE, 8'h00, 13'd4097);
        send_req(ACT_LOOKUP, 8'h00, 13'h1FFF);     // unknown ids
        send_req(ACT_DELETE, 8'hFF, 13'd0);
        send_req(ACT_CREATE, 8'hAA, 13'd4096);     // whole map
        send_req(ACT_CREATE, 8'h55, 13'd1);
        send_req(ACT_LOOKUP, 8'd1, 13'd0);
        send_req(ACT_RESERVED, 8'd1, 13'd0);
        send_req(ACT_DELETE, 8'd1, 13'd0);
        send_req(ACT_DELETE, 8'd1, 13'd0);         // deleted id stays unknown
        send_req(ACT_LOOKUP, 8'd1, 13'd0);
        send_req(ACT_CREATE, 8'h00, 13'd9);
        send_req(ACT_CREATE, 8'h00, 13'd10);
        send_req(ACT_CREATE, 8'h00, 13'd7);
        send_req(ACT_DELETE, 8'd3, 13'd0);         // hole in the middle
        send_req(ACT_CREATE, 8'h00, 13'd12);       // too big for hole
        send_req(ACT_CREATE, 8'h00, 13'd4);        // lands in hole
        send_req(ACT_CREATE, 8'h00, 13'd4085);
        send_req(ACT_CREATE, 8'h00, 13'd4070);
        send_req(ACT_LOOKUP, 8'd6, 13'd0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        repeat (790) send_random();
        wait_drained();
    endtask

    task automatic test_output_stall();
        hold_cycles = 3000;
        repeat (40) send_random();
        wait_drained();
    endtask

    task automatic test_id_exhaustion();
        while (next_id < FILES) begin
            if (live_ids.size() > 20 && $urandom_range(0, 2) == 0)
                send_req(ACT_DELETE, pick_id(), 13'd0);
            else
                send_req(ACT_CREATE, 8'h00, SIZE_W'($urandom_range(1, 30)));
        end
        repeat (100) send_random();
        send_req(ACT_CREATE, 8'hFF, 13'h1FFF);
        wait_drained();
    endtask

    // receiver: changing ready density, plus a counted hold-off
    initial begin
        m_axis_tready = 1'b0;
        ready_pct     = 100;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 199) == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_pct = 100;
                    1:       ready_pct = 70;
                    2:       ready_pct = 30;
                    default: ready_pct = 5;
                endcase
            end
            if (hold_cycles != 0) begin
                hold_cycles--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // result checker
    initial begin
        t_answer want;
        t_answer got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got.status = m_axis_tuser;
                got.id     = m_axis_tdata[7:0];
                got.start  = m_axis_tdata[19:8];
                got.len    = m_axis_tdata[32:20];
                got.ifrag  = m_axis_tdata[44:33];
                got.efrag  = m_axis_tdata[76:45];
                beats_out++;
                if (pending_answers.size() == 0) begin
                    $error("result beat with nothing expected");
                    err_cnt++;
                end else begin
                    want = pending_answers.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_cnt++;
                    end
                    if (got.id !== want.id) begin
                        $error("assigned_id: expected %0d, got %0d", want.id, got.id);
                        err_cnt++;
                    end
                    if (got.start !== want.start) begin
                        $error("run_start: expected %0d, got %0d", want.start, got.start);
                        err_cnt++;
                    end
                    if (got.len !== want.len) begin
                        $error("run_length: expected %0d, got %0d", want.len, got.len);
                        err_cnt++;
                    end
                    if (got.ifrag !== want.ifrag) begin
                        $error("internal_frag: expected %0d, got %0d", want.ifrag, got.ifrag);
                        err_cnt++;
                    end
                    if (got.efrag !== want.efrag) begin
                        $error("external_frag: expected %0d, got %0d", want.efrag, got.efrag);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        err_cnt       = 0;
        beats_in      = 0;
        beats_out     = 0;
        n_ok          = 0;
        n_nospace     = 0;
        n_unknown     = 0;
        n_idsfull     = 0;
        hold_cycles   = 0;
        burst_left    = 0;
        next_id       = 1;
        ifrag_total   = '0;
        efrag_total   = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corner_cases();
        test_random_traffic();
        test_output_stall();
        test_id_exhaustion();

        repeat (1200) @(negedge i_clk);
        $display("covered %0d requests, %0d results: ok %0d, no space %0d, unknown %0d",
                 beats_in, beats_out, n_ok, n_nospace, n_unknown);
        $display("ids exhausted answers %0d, final internal %0d, external %0d",
                 n_idsfull, ifrag_total, efrag_total);
        if (err_cnt == 0 && pending_answers.size() == 0) begin
            $display("[first_fit_contiguous_allocator] OK");
        end else begin
            $display("[first_fit_contiguous_allocator] ERROR");
        end
        $finish;
    end

endmodule
